// ===== rtl/scic_pkg.sv =====
// Package for the set/clear interrupt controller.
// Holds command codes, field widths, the source-to-level table and shared types.
// No dependencies.
`default_nettype none

package scic_pkg;

    localparam int unsigned RegW     = 15;
    localparam int unsigned SrcW     = 4;
    localparam int unsigned LvlW     = 3;
    localparam int unsigned LatW     = 8;
    localparam int unsigned MasterIx = 14;
    localparam int unsigned SetIx    = 15;
    localparam int unsigned TopSrc   = 13;
    localparam logic [LatW-1:0] LatencyReset = 8'd10;

    localparam int unsigned InDataW  = 24;
    localparam int unsigned OutDataW = 24;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_WR_ENA   = 3'd1,
        CMD_WR_REQ   = 3'd2,
        CMD_RD_ENA   = 3'd3,
        CMD_RD_REQ   = 3'd4,
        CMD_REEVAL   = 3'd5
    } cmd_t;

    // Decision of one evaluation pass
    typedef struct packed {
        logic            hit;
        logic [LvlW-1:0] level;
        logic [SrcW-1:0] source;
    } sched_t;

    // One result word
    typedef struct packed {
        logic [SrcW-1:0] irq_source;
        logic [LvlW-1:0] irq_level;
        logic            irq_fire;
        logic [RegW-1:0] read_data;
    } result_t;

    function automatic logic [LvlW-1:0] level_of_source(input logic [SrcW-1:0] src);
        logic [LvlW-1:0] lvl;
        unique case (src)
            4'd0, 4'd1, 4'd2:           lvl = 3'd1;
            4'd3:                       lvl = 3'd2;
            4'd4, 4'd5, 4'd6:           lvl = 3'd3;
            4'd7, 4'd8, 4'd9, 4'd10:    lvl = 3'd4;
            4'd11, 4'd12:               lvl = 3'd5;
            4'd13, 4'd14:               lvl = 3'd6;
            default:                    lvl = 3'd7;
        endcase
        return lvl;
    endfunction

    // Set or clear the masked bits depending on the mode bit
    function automatic logic [RegW-1:0] apply_write(input logic [RegW-1:0] cur,
                                                    input logic [15:0]     data);
        logic [RegW-1:0] mask;
        mask = data[RegW-1:0];
        if (data[SetIx])
            return cur | mask;
        return cur & ~mask;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/set_clear_interrupt_controller_unit.sv =====
// Set/clear interrupt controller, top level. Depends on scic_pkg and scic_eval.
// The result word of an accepted input word is registered in the output stage and driven on m_tdata from there.
// Throughput: one word per cycle while the skid register is empty; a two-entry output stage
// (result + skid register) keeps accepting while one result waits for m_tready.
// Reset (rst_n low, asynchronous): registers and schedule cleared, latency = LatencyReset.
`default_nettype none

module set_clear_interrupt_controller_unit
    import scic_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    // Input words
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [15:0] write_data, [18:16] cpu_level, [19] cpu_raise_busy, [23:20] zero
    input  wire logic [InDataW-1:0]  s_tdata,
    // [2:0] command
    input  wire logic [2:0]          s_tuser,

    // Result words
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [14:0] read_data, [15] irq_fire, [18:16] irq_level, [22:19] irq_source, [23] zero
    output logic [OutDataW-1:0]      m_tdata,

    // Configuration: schedule_latency
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [LatW-1:0]     cfg_data
);

    // Unpack the input word
    logic [15:0]      wdata;
    logic [LvlW-1:0]  cpu_level;
    logic             cpu_busy;
    cmd_t             cmd;

    assign wdata     = s_tdata[15:0];
    assign cpu_level = s_tdata[18:16];
    assign cpu_busy  = s_tdata[19];
    assign cmd       = cmd_t'(s_tuser);

    // Controller state
    logic [LatW-1:0] latency_reg;
    logic [RegW-1:0] enable_reg,    enable_next;
    logic [RegW-1:0] request_reg,   request_next;
    logic            sched_reg,     sched_next;
    logic [LatW-1:0] count_reg,     count_next;
    logic [LvlW-1:0] level_reg,     level_next;
    logic [SrcW-1:0] source_reg,    source_next;

    // Output stage
    logic            out_valid_reg;
    logic            skid_valid_reg;
    result_t         out_reg;
    result_t         skid_reg;
    result_t         res;

    logic            accept;
    logic            take;
    logic            do_eval;
    sched_t          decision;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_reg};
    assign accept    = s_tvalid && s_tready;
    assign take      = out_valid_reg && m_tready;

    // Register writes land before the evaluation sees them
    always_comb
    begin
        enable_next  = enable_reg;
        request_next = request_reg;
        if (cmd == CMD_WR_ENA)
            enable_next = apply_write(enable_reg, wdata);
        if (cmd == CMD_WR_REQ)
            request_next = apply_write(request_reg, wdata);
    end

    assign do_eval = (cmd == CMD_WR_ENA) || (cmd == CMD_WR_REQ) || (cmd == CMD_REEVAL);

    scic_eval u_eval (
        .enable_bits  (enable_next),
        .request_bits (request_next),
        .cpu_level    (cpu_level),
        .cpu_busy     (cpu_busy),
        .scheduled    (sched_reg),
        .decision     (decision)
    );

    // Next schedule state and the result word of this input word
    always_comb
    begin
        sched_next  = sched_reg;
        count_next  = count_reg;
        level_next  = level_reg;
        source_next = source_reg;
        res         = '0;

        unique case (cmd)
            CMD_TICK:
            begin
                if (sched_reg)
                begin
                    if (count_reg <= LatW'(1))
                    begin
                        // Deliver now
                        res.irq_fire   = 1'b1;
                        res.irq_level  = level_reg;
                        res.irq_source = source_reg;
                        sched_next     = 1'b0;
                        count_next     = '0;
                    end
                    else
                    begin
                        count_next = count_reg - LatW'(1);
                    end
                end
            end
            CMD_RD_ENA: res.read_data = enable_reg;
            CMD_RD_REQ: res.read_data = request_reg;
            default:
            begin
            end
        endcase

        if (do_eval && decision.hit)
        begin
            sched_next  = 1'b1;
            count_next  = latency_reg;
            level_next  = decision.level;
            source_next = decision.source;
        end
    end

    // Other state registers advance only on an accepted word; latency_reg loads on a config transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latency_reg <= LatencyReset;
            enable_reg  <= '0;
            request_reg <= '0;
            sched_reg   <= 1'b0;
            count_reg   <= '0;
            level_reg   <= '0;
            source_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                latency_reg <= cfg_data;
            if (accept)
            begin
                enable_reg  <= enable_next;
                request_reg <= request_next;
                sched_reg   <= sched_next;
                count_reg   <= count_next;
                level_reg   <= level_next;
                source_reg  <= source_next;
            end
        end
    end

    // Output and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                // Move the held word forward once the output drains
                if (take)
                    skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                if (out_valid_reg && !take)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scic_eval.sv =====
// Evaluation pass of the set/clear interrupt controller.
// Picks the highest pending source and decides whether to schedule it.
// Depends on scic_pkg.
`default_nettype none

module scic_eval
    import scic_pkg::*;
(
    input  wire logic [RegW-1:0] enable_bits,
    input  wire logic [RegW-1:0] request_bits,
    input  wire logic [LvlW-1:0] cpu_level,
    input  wire logic            cpu_busy,
    input  wire logic            scheduled,
    output sched_t               decision
);

    logic [RegW-1:0] pending;
    logic            found;
    logic [SrcW-1:0] top_src;
    logic [LvlW-1:0] top_lvl;

    assign pending = enable_bits & request_bits;

    // Highest set bit among the sources; the master bit never counts
    always_comb
    begin
        found   = 1'b0;
        top_src = '0;
        for (int i = 0; i <= TopSrc; i++)
        begin
            if (pending[i])
            begin
                found   = 1'b1;
                top_src = SrcW'(i);
            end
        end
    end

    assign top_lvl = level_of_source(top_src);

    always_comb
    begin
        decision.hit    = enable_bits[MasterIx] && found && !scheduled && !cpu_busy
                          && (top_lvl > cpu_level);
        decision.level  = top_lvl;
        decision.source = top_src;
    end

endmodule

`default_nettype wire

// ===== test/scic_result_checker.sv =====
// Result checker for the set/clear interrupt controller testbench.
// Watches the input, result and configuration channels, predicts each result
// word and compares it with the block's output. Depends on scic_pkg.
`default_nettype none

module scic_result_checker
    import scic_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [InDataW-1:0]  s_tdata,
    input  wire logic [2:0]          s_tuser,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [OutDataW-1:0] m_tdata,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [LatW-1:0]     cfg_data,
    output int unsigned              mismatches,
    output int unsigned              outstanding,
    output int unsigned              words_compared,
    output int unsigned              deliveries
);

    // CPU level per source, entry 0 in the lowest bits
    localparam logic [16*LvlW-1:0] LevelTable = {
        3'd7, 3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1
    };

    logic [RegW-1:0] enables;
    logic [RegW-1:0] requests;
    logic            armed;
    logic [LatW-1:0] countdown;
    logic [LatW-1:0] latency;
    logic [LvlW-1:0] armed_level;
    logic [SrcW-1:0] armed_source;
    result_t         expected_words[$];

    function automatic logic [RegW-1:0] merge_word(input logic [RegW-1:0] cur,
                                                   input logic [15:0]     data);
        if (data[SetIx])
            return cur | data[RegW-1:0];
        return cur & ~data[RegW-1:0];
    endfunction

    // Arm a delivery for the highest pending source if its level beats the cpu
    task automatic try_schedule(input logic [LvlW-1:0] cpu, input logic busy);
        logic [RegW-1:0] live;
        bit              found;
        int              s;
        live  = enables & requests;
        found = 1'b0;
        if (!enables[MasterIx] || live == '0 || armed || busy)
            return;
        for (s = TopSrc; s >= 0 && !found; s--) begin
            if (live[s]) begin
                found = 1'b1;
                if (LevelTable[s*LvlW +: LvlW] > cpu) begin
                    armed_source = SrcW'(s);
                    armed_level  = LevelTable[s*LvlW +: LvlW];
                    countdown    = latency;
                    armed        = 1'b1;
                end
            end
        end
    endtask

    always @(posedge clk) begin : watch
        result_t         want;
        result_t         got;
        logic [15:0]     data;
        logic [LvlW-1:0] cpu;
        logic            busy;
        if (!rst_n) begin
            enables        = '0;
            requests       = '0;
            armed          = 1'b0;
            countdown      = '0;
            latency        = LatencyReset;
            armed_level    = '0;
            armed_source   = '0;
            expected_words.delete();
            mismatches     <= 0;
            words_compared <= 0;
            deliveries     <= 0;
            outstanding    <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                latency = cfg_data;

            if (s_tvalid && s_tready) begin
                data = s_tdata[15:0];
                cpu  = s_tdata[18:16];
                busy = s_tdata[19];
                want = '0;
                case (s_tuser)
                    CMD_TICK: begin
                        if (armed) begin
                            if (countdown <= 1) begin
                                want.irq_fire   = 1'b1;
                                want.irq_level  = armed_level;
                                want.irq_source = armed_source;
                                armed           = 1'b0;
                                countdown       = '0;
                            end else begin
                                countdown = countdown - 1'b1;
                            end
                        end
                    end
                    CMD_WR_ENA: begin
                        enables = merge_word(enables, data);
                        try_schedule(cpu, busy);
                    end
                    CMD_WR_REQ: begin
                        requests = merge_word(requests, data);
                        try_schedule(cpu, busy);
                    end
                    CMD_RD_ENA: want.read_data = enables;
                    CMD_RD_REQ: want.read_data = requests;
                    CMD_REEVAL: try_schedule(cpu, busy);
                    default: ;
                endcase
                expected_words.push_back(want);
            end

            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(result_t)-1:0];
                if (expected_words.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result word %h arrived with nothing expected",
                                 $time, m_tdata);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_words.pop_front();
                    words_compared <= words_compared + 1;
                    if (got.irq_fire)
                        deliveries <= deliveries + 1;
                    if (got.read_data != want.read_data || got.irq_fire != want.irq_fire ||
                        got.irq_level != want.irq_level ||
                        got.irq_source != want.irq_source ||
                        m_tdata[OutDataW-1:$bits(result_t)] != '0) begin
                        if (mismatches < 10)
                            $display({"%0t: read_data %h/%h fire %b/%b level %0d/%0d ",
                                      "source %0d/%0d pad %b (expected/actual)"},
                                     $time, want.read_data, got.read_data,
                                     want.irq_fire, got.irq_fire,
                                     want.irq_level, got.irq_level,
                                     want.irq_source, got.irq_source,
                                     m_tdata[OutDataW-1:$bits(result_t)]);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            outstanding <= expected_words.size();
        end
    end

endmodule

`default_nettype wire

// ===== test/set_clear_interrupt_controller_unit_tb.sv =====
// Testbench top for the set/clear interrupt controller: clock, reset, stimulus,
// receiver back-pressure and the verdict. Depends on scic_pkg, the block and
// scic_result_checker, which predicts and compares every result word.
`default_nettype none

module set_clear_interrupt_controller_unit_tb;
    import scic_pkg::*;

    // Command codes the block leaves unused
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    // Receiver hold-off long enough to fill the output stage and stall input
    localparam int unsigned LongHold = 64;
    localparam int unsigned PhaseWords = 240;

    // Latency per random phase, phase 0 in the lowest byte
    localparam logic [7*LatW-1:0] LatencyPlan = {
        8'd5, 8'd64, 8'd2, 8'd12, 8'd255, 8'd1, 8'd3
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic [2:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LatW-1:0]     cfg_data;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned words_compared;
    int unsigned deliveries;

    int unsigned words_sent;
    int unsigned latency_writes;
    int unsigned hold_requests;
    int unsigned holds_done;
    bit          no_idle;

    always #1 clk = ~clk;

    set_clear_interrupt_controller_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    scic_result_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .words_compared (words_compared),
        .deliveries     (deliveries)
    );

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one word and hold it until the block takes it.
    // Enter and leave just after a falling edge; tvalid stays high between
    // back-to-back words so it is never dropped and raised in one step.
    task automatic send_word(input logic [2:0] cmd, input logic [15:0] data,
                             input logic [LvlW-1:0] cpu, input logic busy);
        int unsigned gap;
        gap = no_idle ? 0 : gap_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, busy, cpu, data};
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        words_sent++;
    endtask

    // Stop offering and wait until every expected result word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    // Write the latency register while the block is idle
    task automatic set_latency(input logic [LatW-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        latency_writes++;
    endtask

    // Receiver: random stalls, plus a long hold-off whenever the sender asks
    initial begin : rx_side
        int unsigned stall;
        m_tready = 1'b0;
        stall    = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (LongHold) @(negedge clk);
            end else if (stall != 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle)
                    stall = gap_len();
            end
        end
    end

    initial begin : stimulus
        int unsigned      p;
        int unsigned      i;
        int unsigned      r;
        int unsigned      tick_pct;
        logic [LatW-1:0]  lat;
        logic [2:0]       cmd;
        logic [15:0]      data;
        logic [RegW-2:0]  mask;
        logic [LvlW-1:0]  cpu;
        logic             busy;

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_TICK;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        words_sent     = 0;
        latency_writes = 0;
        hold_requests  = 0;
        holds_done     = 0;
        no_idle        = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset latency of ten ticks.
        // Read both registers straight out of reset
        send_word(CMD_RD_ENA, 16'h0000, 3'd0, 1'b0);
        send_word(CMD_RD_REQ, 16'hFFFF, 3'd7, 1'b1);
        // Enable every source but leave the master bit off: nothing schedules
        send_word(CMD_WR_ENA, 16'hBFFF, 3'd0, 1'b0);
        // Request only the master bit position, then turn the master on:
        // bit fourteen pending alone must not schedule anything
        send_word(CMD_WR_REQ, 16'hC000, 3'd0, 1'b0);
        send_word(CMD_WR_ENA, 16'hC000, 3'd0, 1'b0);
        // Enable read returns the master bit too
        send_word(CMD_RD_ENA, 16'h0000, 3'd0, 1'b0);
        // Source 13 at the cpu level blocks the search, source 0 is not reached
        send_word(CMD_WR_REQ, 16'hA001, 3'd6, 1'b0);
        // Cpu busy raising: hold off; then schedule; then nothing while armed
        send_word(CMD_REEVAL, 16'h0000, 3'd2, 1'b1);
        send_word(CMD_REEVAL, 16'h0000, 3'd2, 1'b0);
        send_word(CMD_REEVAL, 16'hFFFF, 3'd0, 1'b0);
        // Unused commands change nothing
        send_word(CMD_SPARE_A, 16'hFFFF, 3'd7, 1'b1);
        send_word(CMD_SPARE_B, 16'h0000, 3'd0, 1'b0);
        // Delivery lands on the tenth tick
        repeat (10) send_word(CMD_TICK, 16'h0000, 3'd0, 1'b0);
        // Clear all requests; a clear with an empty mask leaves enables alone
        send_word(CMD_WR_REQ, 16'h7FFF, 3'd0, 1'b0);
        send_word(CMD_WR_ENA, 16'h0000, 3'd7, 1'b0);

        // Shortest latency fires on the first tick
        set_latency(8'd1);
        send_word(CMD_WR_REQ, 16'hFFFF, 3'd0, 1'b0);
        send_word(CMD_TICK, 16'h0000, 3'd0, 1'b0);
        // A zero latency setting behaves like the shortest nonzero one
        set_latency(8'd0);
        send_word(CMD_REEVAL, 16'h0000, 3'd0, 1'b0);
        send_word(CMD_TICK, 16'h0000, 3'd0, 1'b0);
        send_word(CMD_WR_REQ, 16'h7FFF, 3'd0, 1'b0);

        // Random phases, one latency setting each
        for (p = 0; p < 7; p++) begin
            lat = LatencyPlan[p*LatW +: LatW];
            set_latency(lat);
            // Long latencies need many ticks before anything fires
            tick_pct = (lat > 32) ? 80 : 40;
            no_idle  = (p == 3);
            for (i = 0; i < PhaseWords; i++) begin
                // Phase 1: starve the receiver while the sender keeps going,
                // then pause the sender until every result is back
                if (p == 1 && i == 80) begin
                    no_idle = 1'b1;
                    hold_requests++;
                end
                if (p == 1 && i == 140)
                    no_idle = 1'b0;
                if (p == 1 && i == 160)
                    drain();

                mask = (RegW-1)'($urandom & $urandom);
                data = 16'($urandom);
                cpu  = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                   : 3'($urandom_range(0, 2));
                busy = ($urandom_range(0, 4) == 0);
                r    = $urandom_range(0, 99);
                if (r < tick_pct) begin
                    cmd = CMD_TICK;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 25) begin
                        cmd = CMD_WR_ENA;
                        // Mostly set sources with the master on
                        if ($urandom_range(0, 3) != 0)
                            data = {2'b11, mask};
                    end else if (r < 55) begin
                        cmd = CMD_WR_REQ;
                        r = $urandom_range(0, 99);
                        if (r < 55)
                            data = {1'b1, 1'b0, mask};
                        else if (r < 90)
                            data = {1'b0, 1'b0, mask};
                    end else if (r < 70) begin
                        cmd = CMD_RD_ENA;
                    end else if (r < 82) begin
                        cmd = CMD_RD_REQ;
                    end else if (r < 95) begin
                        cmd = CMD_REEVAL;
                    end else begin
                        cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
                    end
                end
                send_word(cmd, data, cpu, busy);
            end
        end
        no_idle = 1'b0;

        // Wait out the last results and the output stage
        drain();
        repeat (8) @(negedge clk);

        $display("Sent %0d command words over %0d latency settings, %0d results compared,",
                 words_sent, latency_writes, words_compared);
        $display("%0d interrupt deliveries seen, %0d long receiver hold-off(s).",
                 deliveries, holds_done);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Guard against a hang
    initial begin : watchdog
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
